// File: hdl/uts_pkg.sv
// ============================================================================
// uts_pkg
// Shared types for the unordered table with swap-on-remove.
// ============================================================================
`default_nettype none

package uts_pkg;

  // Operation codes carried on in_opcode.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_ERASE  = 2'd3
  } opcode_t;

  // Result status codes reported on out_status.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // Widths fixed by the port fields.
  localparam int unsigned DataW  = 32;
  localparam int unsigned IndexW = 8;
  localparam int unsigned CountW = 9;

endpackage

`default_nettype wire

// File: hdl/uts_mem.sv
// ============================================================================
// uts_mem
// Entry store: one write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module uts_mem #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output logic [uts_pkg::DataW-1:0]      rd_data,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [uts_pkg::DataW-1:0] wr_data
);

  logic [uts_pkg::DataW-1:0] mem [DEPTH];
  logic [uts_pkg::DataW-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/unordered_table_swap_remove.sv
// ============================================================================
// unordered_table_swap_remove
// Fixed-depth unordered table of 32-bit words with swap-with-last removal.
// ============================================================================
//
//  channel  | handshake           | fields
//  ---------+---------------------+------------------------------------------
//  input    | start, busy         | in_opcode, in_value, in_index
//  result   | out_valid (strobe)  | out_read_data, out_status, out_count,
//           |                     | out_is_empty
//
//  Append, removal from an empty table and an out-of-range read or erase are
//  answered straight from idle; read passes through S_READ and erase through
//  S_ERASE and S_LAST. Remove-by-value sweeps the single read port of the
//  entry store one entry per cycle from the front; a match goes on to S_LAST.
//  A transfer on the input is taken when start is high and busy is low; the
//  result follows on out_valid for one cycle and cannot be stalled.
//  Reset clears state, count and out_valid; entries >= count are never read.
//
`default_nettype none

module unordered_table_swap_remove #(
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_opcode,
  input  wire logic signed [uts_pkg::DataW-1:0] in_value,
  input  wire logic [uts_pkg::IndexW-1:0]       in_index,
  output logic                                  out_valid,
  output logic signed [uts_pkg::DataW-1:0]      out_read_data,
  output logic [1:0]                            out_status,
  output logic [uts_pkg::CountW-1:0]            out_count,
  output logic                                  out_is_empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > uts_pkg::IndexW) ? CW : uts_pkg::IndexW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_ERASE,
    S_LAST
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              scan_addr_r, scan_addr_nxt;
  logic                       pend_r, pend_nxt;
  logic [AW-1:0]              pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]              hit_pos_r, hit_pos_nxt;
  logic [uts_pkg::DataW-1:0]  value_r, value_nxt;
  logic [uts_pkg::DataW-1:0]  data_r, data_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [uts_pkg::DataW-1:0]  out_data_r, out_data_nxt;
  uts_pkg::status_t           out_status_r, out_status_nxt;
  logic [uts_pkg::CountW-1:0] out_count_r, out_count_nxt;
  logic                       out_empty_r, out_empty_nxt;

  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [uts_pkg::DataW-1:0]  rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [uts_pkg::DataW-1:0]  wr_data;

  logic                       accept;
  logic                       in_range;
  logic                       is_full;
  logic [AW-1:0]              last_addr;

  uts_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign in_range  = CMPW'(in_index) < CMPW'(count_r);
  assign is_full   = count_r == CW'(DEPTH);
  assign last_addr = AW'(count_r - CW'(1));

  // Sequencer: decode, entry store accesses and result formation.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_addr_nxt  = scan_addr_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    hit_pos_nxt    = hit_pos_r;
    value_nxt      = value_r;
    data_nxt       = data_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    out_status_nxt = uts_pkg::ST_DONE;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          value_nxt = in_value;
          case (uts_pkg::opcode_t'(in_opcode))
            uts_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = uts_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AW'(count_r);
                wr_data   = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            uts_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = uts_pkg::ST_NOTFOUND;
              end else begin
                // Start the sweep at entry zero.
                rd_en         = 1'b1;
                rd_addr       = '0;
                pend_nxt      = 1'b1;
                pend_addr_nxt = '0;
                scan_addr_nxt = CW'(1);
                state_nxt     = S_SCAN;
              end
            end
            uts_pkg::OP_READ, uts_pkg::OP_ERASE: begin
              if (!in_range) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = uts_pkg::ST_RANGE;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = AW'(in_index);
                hit_pos_nxt = AW'(in_index);
                state_nxt   = (in_opcode == uts_pkg::OP_READ) ? S_READ : S_ERASE;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end

      S_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_data;
        state_nxt     = S_IDLE;
      end

      S_SCAN: begin
        if (pend_r && (rd_data == value_r)) begin
          // Match found: fetch the last entry to fill the hole.
          hit_pos_nxt = pend_addr_r;
          data_nxt    = '0;
          rd_en       = 1'b1;
          rd_addr     = last_addr;
          state_nxt   = S_LAST;
        end else if (scan_addr_r < count_r) begin
          rd_en         = 1'b1;
          rd_addr       = AW'(scan_addr_r);
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(scan_addr_r);
          scan_addr_nxt = scan_addr_r + CW'(1);
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = uts_pkg::ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end
      end

      S_ERASE: begin
        // Keep the erased entry and fetch the last one.
        data_nxt  = rd_data;
        rd_en     = 1'b1;
        rd_addr   = last_addr;
        state_nxt = S_LAST;
      end

      S_LAST: begin
        wr_en         = 1'b1;
        wr_addr       = hit_pos_r;
        wr_data       = rd_data;
        count_nxt     = count_r - CW'(1);
        out_valid_nxt = 1'b1;
        out_data_nxt  = data_r;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_count_nxt = uts_pkg::CountW'(count_nxt);
    out_empty_nxt = (count_nxt == '0);
  end

  // State, count and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_addr_r  <= scan_addr_nxt;
    pend_addr_r  <= pend_addr_nxt;
    hit_pos_r    <= hit_pos_nxt;
    value_r      <= value_nxt;
    data_r       <= data_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_is_empty  = out_empty_r;

endmodule

`default_nettype wire

// File: hdl/uts_checker.sv
// ============================================================================
// uts_checker
// Port-level checks on the table's command and result transfers.
// ============================================================================
`default_nettype none

module uts_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             out_valid,
  input wire logic signed [uts_pkg::DataW-1:0] out_read_data,
  input wire logic [1:0]                       out_status,
  input wire logic [uts_pkg::CountW-1:0]       out_count,
  input wire logic                             out_is_empty
);

  // Every accepted command is either answered at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted command neither answered nor in progress");

  // The end of a multi-cycle operation always delivers its result.
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result transfer");

  // No result transfer is issued while a command is in progress.
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> !out_valid)
    else $error("result transfer in the middle of an operation");

  // The empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // Failed operations return zero data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != uts_pkg::ST_DONE)) |-> (out_read_data == '0))
    else $error("failed operation returned non-zero data");

endmodule

bind unordered_table_swap_remove uts_checker u_uts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_read_data (out_read_data),
  .out_status    (out_status),
  .out_count     (out_count),
  .out_is_empty  (out_is_empty)
);

`default_nettype wire
